// File: rtl/pcs_pkg.sv
// Shared types and constants for the PID controller with slew and settle logic.
// Used by every module of the block; depends on nothing.
package pcs_pkg;

  localparam int unsigned UpdateMsDef = 10;
  localparam int SmoothQ8 = 128;

  localparam int ErrW = 32;
  localparam int DiffW = 33;
  localparam int GainW = 24;
  localparam int LimW = 20;
  localparam int BandW = 31;
  localparam int CntW = 20;
  localparam int IntegW = 22;
  localparam int DerivW = 40;
  localparam int DriveW = 21;
  localparam int AccW = 64;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 31;

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [CfgIdxW-1:0] CfgPGain = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIGain = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDGain = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOutLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSlewLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSettleBand = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSettleMs = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgTimeoutMs = 3'd7;

  typedef struct packed {
    logic signed [ErrW-1:0] error_sample;
    logic                   restart;
  } pcs_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     done_res;
  } pcs_out_t;

  typedef struct packed {
    logic                  start;
    logic                  clr;
    logic [AccW-1:0]       opnd;
    logic [GainW-1:0]      mult;
  } pcs_mac_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_FILT, S_MP, S_MI, S_MD, S_CLAMP, S_FIN
  } pcs_state_e;

endpackage

// File: rtl/pid_controller_slew_settle.sv
// PID controller with filtered derivative, clamped integral, output clamp, slew limit and settle/timeout.
// The result beat is offered after the input beat is taken and passes 33 divider steps,
// a filter step, three 24-step passes of the serial multiply-accumulate, a clamp step and
// an output step. The next input beat can be taken in the cycle the result is offered; no
// item enters before the last is through; a stalled result holds the next in its last step.
// Reset clears loop state and loads register defaults. Depends on pcs_pkg, pcs_div, pcs_mac.
module pid_controller_slew_settle import pcs_pkg::*; #(
  parameter int unsigned UPDATE_MS = UpdateMsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcs_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic signed [45:0] UpdC = 46'(UPDATE_MS);
  localparam logic signed [49:0] SmoothC = 50'(SmoothQ8);
  localparam logic signed [49:0] KeepC = 50'(256 - SmoothQ8);
  localparam logic [CntW:0] UpdCnt = (CntW + 1)'(UPDATE_MS);

  pcs_state_e state_q, state_d;

  logic [GainW-1:0] p_gain_q, i_gain_q, d_gain_q;
  logic [LimW-1:0]  lim_q, slew_q;
  logic [BandW-1:0] band_q;
  logic [CntW-1:0]  settle_ms_q, timeout_q;

  logic signed [ErrW-1:0]   e_q, last_error_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [DerivW-1:0] df_q;
  logic signed [DriveW-1:0] last_drive_q;
  logic [CntW-1:0]          elapsed_q, settled_q;
  logic                     neg_q;
  logic signed [IntegW-1:0] tc_q;
  pcs_out_t                 out_q;
  logic                     out_valid_q;

  logic                   in_acc, out_free, div_done, mac_done;
  logic signed [ErrW-1:0] le_eff;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]       diff_mag, quo;
  logic [AccW-1:0]        acc;
  pcs_mac_cmd_t           mac_cmd;

  logic signed [33:0]     raw;
  logic signed [49:0]     f_sum;
  logic signed [33:0]     es;
  logic signed [45:0]     iprod, isum, lim46;
  logic signed [IntegW-1:0] integ_new;
  logic signed [AccW-1:0] tgt, lim64;
  logic signed [IntegW-1:0] tc_new;
  logic [CntW:0]          el_sum, st_sum;
  logic [DiffW-1:0]       e_mag;
  logic signed [22:0]     ld23, sl23, hi, lo, tc23, drv;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign le_eff   = in_data_i.restart ? '0 : last_error_q;
  assign diff     = DiffW'(in_data_i.error_sample) - DiffW'(le_eff);
  assign diff_mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

  pcs_div #(.UPDATE_MS(UPDATE_MS)) u_div (
    .clk_i, .rst_ni, .start_i(in_acc), .dividend_i(diff_mag),
    .done_o(div_done), .quotient_o(quo)
  );

  pcs_mac u_mac (
    .clk_i, .rst_ni, .cmd_i(mac_cmd), .done_o(mac_done), .acc_o(acc)
  );

  always_comb begin
    raw   = neg_q ? -34'(quo) : 34'(quo);
    f_sum = 50'(df_q) * SmoothC + 50'(raw) * KeepC;
    es    = 34'(e_q) + 34'(last_error_q);
    iprod = 46'(es) * UpdC;
    isum  = 46'(integ_q) + (iprod >>> 1);
    lim46 = 46'({1'b0, lim_q});
    if (isum > lim46) begin
      integ_new = IntegW'(lim46);
    end else if (isum < -lim46) begin
      integ_new = IntegW'(-lim46);
    end else begin
      integ_new = IntegW'(isum);
    end
    tgt   = $signed(acc) >>> 16;
    lim64 = AccW'({1'b0, lim_q});
    if (tgt > lim64) begin
      tc_new = IntegW'(lim64);
    end else if (tgt < -lim64) begin
      tc_new = IntegW'(-lim64);
    end else begin
      tc_new = IntegW'(tgt);
    end
    el_sum = {1'b0, elapsed_q} + UpdCnt;
    st_sum = {1'b0, settled_q} + UpdCnt;
    e_mag  = e_q[ErrW-1] ? DiffW'(-DiffW'(e_q)) : DiffW'(e_q);
    ld23   = 23'(last_drive_q);
    sl23   = 23'({1'b0, slew_q});
    hi     = ld23 + sl23;
    lo     = ld23 - sl23;
    tc23   = 23'(tc_q);
    if (tc23 > hi) begin
      drv = hi;
    end else if (tc23 < lo) begin
      drv = lo;
    end else begin
      drv = tc23;
    end
  end

  always_comb begin
    state_d       = state_q;
    mac_cmd.start = 1'b0;
    mac_cmd.clr   = 1'b0;
    mac_cmd.opnd  = AccW'(e_q);
    mac_cmd.mult  = p_gain_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FILT;
        end
      end
      S_FILT: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clr   = 1'b1;
        state_d       = S_MP;
      end
      S_MP: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.opnd  = AccW'(integ_q);
          mac_cmd.mult  = i_gain_q;
          state_d       = S_MI;
        end
      end
      S_MI: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.opnd  = AccW'(df_q);
          mac_cmd.mult  = d_gain_q;
          state_d       = S_MD;
        end
      end
      S_MD: begin
        if (mac_done) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      p_gain_q     <= '0;
      i_gain_q     <= '0;
      d_gain_q     <= '0;
      lim_q        <= LimW'(786432);
      slew_q       <= '1;
      band_q       <= '0;
      settle_ms_q  <= '0;
      timeout_q    <= '1;
      last_error_q <= '0;
      integ_q      <= '0;
      df_q         <= '0;
      last_drive_q <= '0;
      elapsed_q    <= '0;
      settled_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPGain:      p_gain_q    <= cfg_data_i[GainW-1:0];
          CfgIGain:      i_gain_q    <= cfg_data_i[GainW-1:0];
          CfgDGain:      d_gain_q    <= cfg_data_i[GainW-1:0];
          CfgOutLimit:   lim_q       <= cfg_data_i[LimW-1:0];
          CfgSlewLimit:  slew_q      <= cfg_data_i[LimW-1:0];
          CfgSettleBand: band_q      <= cfg_data_i[BandW-1:0];
          CfgSettleMs:   settle_ms_q <= cfg_data_i[CntW-1:0];
          CfgTimeoutMs:  timeout_q   <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && in_data_i.restart) begin
        last_error_q <= '0;
        integ_q      <= '0;
        df_q         <= '0;
        last_drive_q <= '0;
        elapsed_q    <= '0;
        settled_q    <= '0;
      end
      if (state_q == S_FILT) begin
        df_q         <= DerivW'(f_sum >>> 8);
        integ_q      <= integ_new;
        last_error_q <= e_q;
      end
      if (state_q == S_CLAMP) begin
        elapsed_q <= (el_sum > {1'b0, CntMax}) ? CntMax : CntW'(el_sum);
        if (e_mag <= DiffW'(band_q)) begin
          settled_q <= (st_sum > {1'b0, CntMax}) ? CntMax : CntW'(st_sum);
        end else begin
          settled_q <= '0;
        end
      end
      if (state_q == S_FIN && out_free) begin
        last_drive_q <= DriveW'(drv);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q   <= in_data_i.error_sample;
      neg_q <= diff[DiffW-1];
    end
    if (state_q == S_CLAMP) begin
      tc_q <= tc_new;
    end
    if (state_q == S_FIN && out_free) begin
      out_q.drive    <= DriveW'(drv);
      out_q.done_res <= (elapsed_q >= timeout_q) || (settled_q >= settle_ms_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/pcs_div.sv
// Bit-serial restoring divider by the constant update period.
// Produces one quotient bit per cycle; depends on pcs_pkg.
module pcs_div import pcs_pkg::*; #(
  parameter int unsigned UPDATE_MS = UpdateMsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DiffW-1:0] dividend_i,
  output logic             done_o,
  output logic [DiffW-1:0] quotient_o
);

  localparam int RemW = $clog2(UPDATE_MS + 1);
  localparam int CntBits = $clog2(DiffW + 1);
  localparam logic [RemW:0] Divisor = (RemW + 1)'(UPDATE_MS);

  logic [RemW-1:0]    rem_q, rem_d;
  logic [DiffW-1:0]   quo_q, quo_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [RemW:0]      trial;
  logic               fits;

  always_comb begin
    trial = {rem_q, quo_q[DiffW-1]};
    fits  = trial >= Divisor;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CntBits'(DiffW);
    end else if (cnt_q != '0) begin
      rem_d = fits ? RemW'(trial - Divisor) : RemW'(trial);
      quo_d = {quo_q[DiffW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = (cnt_q == CntBits'(1));
  assign quotient_o = quo_q;

endmodule

// File: rtl/pcs_mac.sv
// Bit-serial multiply-accumulate: one gain bit per cycle into a 64-bit sum.
// Depends on pcs_pkg for the command struct and widths.
module pcs_mac import pcs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pcs_mac_cmd_t    cmd_i,
  output logic            done_o,
  output logic [AccW-1:0] acc_o
);

  localparam int CntBits = $clog2(GainW + 1);

  logic [AccW-1:0]    acc_q, acc_d, opnd_q, opnd_d, addend;
  logic [GainW-1:0]   mult_q, mult_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  always_comb begin
    addend = (cnt_q != '0 && mult_q[0]) ? opnd_q : '0;
    acc_d  = cmd_i.clr ? '0 : acc_q + addend;
    opnd_d = {opnd_q[AccW-2:0], 1'b0};
    mult_d = {1'b0, mult_q[GainW-1:1]};
    cnt_d  = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    if (cmd_i.start) begin
      opnd_d = cmd_i.opnd;
      mult_d = cmd_i.mult;
      cnt_d  = CntBits'(GainW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    mult_q <= mult_d;
  end

  assign done_o = (cnt_q == CntBits'(1));
  assign acc_o  = acc_q;

endmodule

// File: rtl/pcs_chk.sv
// Port-level checker for the PID controller, bound to the top level.
// Depends on pcs_pkg and pid_controller_slew_settle.
module pcs_chk import pcs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input pcs_in_t             in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pcs_out_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat changed while stalled.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input taken again before the item was finished.");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("Result appeared one cycle after the input beat.");

  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("Block left idle without an input beat.");

endmodule

bind pid_controller_slew_settle pcs_chk u_pcs_chk (.*);

// File: verif/pid_controller_slew_settle_tb.sv
// Self-checking testbench for the PID controller with slew limit and settle detection.
// Predicts drive and done for every beat and compares them with the block's results.
// Depends on pcs_pkg and the pid_controller_slew_settle RTL.
module pid_controller_slew_settle_tb;
  import pcs_pkg::*;

  localparam int unsigned UpdMs = 10;
  localparam longint CntSat = 1048575;
  localparam int Latency = 200;
  localparam int HoldCycles = 400;
  localparam longint CycleLimit = 2000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pcs_in_t in_data;
  pcs_out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  pid_controller_slew_settle dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Predictor copy of registers and loop state.
  longint kp, ki, kd, lim_reg, slew_reg, band_reg, settle_reg, tmo_reg;
  longint prev_err, integ, deriv, prev_drive, elapsed, settled;

  pcs_out_t drive_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_off = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = 1'b1;
      #4 clk = 1'b0;
    end
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_lim(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic longint sat_cnt(longint v);
    return (v > CntSat) ? CntSat : v;
  endfunction

  function automatic void reset_loop();
    prev_err = 0; integ = 0; deriv = 0; prev_drive = 0; elapsed = 0; settled = 0;
  endfunction

  function automatic pcs_out_t predict_drive(pcs_in_t it);
    longint e, raw, acc, tgt, drv, mag;
    pcs_out_t r;
    e = longint'(it.error_sample);
    if (it.restart) reset_loop();
    raw = (e - prev_err) / longint'(UpdMs);
    deriv = floor_sh(SmoothQ8 * deriv + (256 - SmoothQ8) * raw, 8);
    integ = clamp_lim(integ + floor_sh(longint'(UpdMs) * (e + prev_err), 1), lim_reg);
    prev_err = e;
    acc = e * kp + integ * ki + deriv * kd;
    tgt = clamp_lim(floor_sh(acc, 16), lim_reg);
    if (tgt > prev_drive + slew_reg) drv = prev_drive + slew_reg;
    else if (tgt < prev_drive - slew_reg) drv = prev_drive - slew_reg;
    else drv = tgt;
    prev_drive = drv;
    elapsed = sat_cnt(elapsed + UpdMs);
    mag = (e < 0) ? -e : e;
    settled = (mag <= band_reg) ? sat_cnt(settled + UpdMs) : 0;
    r.drive = drv[DriveW-1:0];
    r.done_res = (elapsed >= tmo_reg) || (settled >= settle_reg);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pcs_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      checked++;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result drive=%0d done=%0b", $time,
                 out_data.drive, out_data.done_res);
        errors++;
      end else begin
        exp_r = drive_q.pop_front();
        if (out_data.drive !== exp_r.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time,
                   exp_r.drive, out_data.drive);
          errors++;
        end
        if (out_data.done_res !== exp_r.done_res) begin
          $display("%0t: done expected %0b actual %0b", $time,
                   exp_r.done_res, out_data.done_res);
          errors++;
        end
      end
    end
  end

  task automatic send_beat(logic signed [ErrW-1:0] e, logic rs);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{error_sample: e, restart: rs};
    do @(posedge clk); while (!in_ready);
    drive_q.push_back(predict_drive('{error_sample: e, restart: rs}));
    sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (drive_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgPGain: kp = val & 24'hFFFFFF;
      CfgIGain: ki = val & 24'hFFFFFF;
      CfgDGain: kd = val & 24'hFFFFFF;
      CfgOutLimit: lim_reg = val & 20'hFFFFF;
      CfgSlewLimit: slew_reg = val & 20'hFFFFF;
      CfgSettleBand: band_reg = val & 31'h7FFFFFFF;
      CfgSettleMs: settle_reg = val & 20'hFFFFF;
      CfgTimeoutMs: tmo_reg = val & 20'hFFFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [ErrW-1:0] rand_err();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2000000)) - 1000000;
      2: return $signed($urandom_range(200)) - 100;
      default: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  task automatic random_config();
    write_reg(CfgPGain, ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                               : $urandom_range(24'h3FFFF));
    write_reg(CfgIGain, $urandom_range(24'hFFFF));
    write_reg(CfgDGain, $urandom_range(24'h3FFFF));
    write_reg(CfgOutLimit, $urandom_range(20'hFFFFF));
    write_reg(CfgSlewLimit, $urandom_range(20'hFFFFF));
    write_reg(CfgSettleBand, ($urandom_range(1)) ? $urandom_range(500) : $urandom);
    write_reg(CfgSettleMs, $urandom_range(300));
    write_reg(CfgTimeoutMs, $urandom_range(3000));
  endtask

  task automatic test_reset_defaults();
    send_beat(32'sh00010000, 1'b0);
    send_beat(-32'sh00010000, 1'b0);
    wait_drained();
  endtask

  task automatic test_extremes();
    write_reg(CfgPGain, 24'hFFFFFF);
    write_reg(CfgIGain, 24'hFFFFFF);
    write_reg(CfgDGain, 24'hFFFFFF);
    write_reg(CfgOutLimit, 20'hFFFFF);
    write_reg(CfgSlewLimit, 20'h08000);
    write_reg(CfgSettleBand, 31'h7FFFFFFF);
    write_reg(CfgSettleMs, 20'hFFFFF);
    write_reg(CfgTimeoutMs, 20'hFFFFF);
    send_beat(32'sh7FFFFFFF, 1'b1);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh7FFFFFFF, 1'b0);
    send_beat(32'sh0, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sh80000000, 1'b1);
    wait_drained();
    // Lowering the limit below the last drive while slewing slowly.
    write_reg(CfgOutLimit, 20'h00100);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh7FFFFFFF, 1'b0);
    wait_drained();
    write_reg(CfgOutLimit, 20'h0);
    write_reg(CfgSlewLimit, 20'h0);
    wait_drained();
    send_beat(32'sh00050000, 1'b0);
    wait_drained();
    write_reg(CfgSlewLimit, 20'hFFFFF);
    write_reg(CfgOutLimit, 20'hC0000);
    wait_drained();
  endtask

  task automatic test_settle_timeout();
    write_reg(CfgSettleBand, 31'd100);
    write_reg(CfgSettleMs, 20'd30);
    write_reg(CfgTimeoutMs, 20'd60);
    send_beat(32'sd50, 1'b1);
    send_beat(-32'sd100, 1'b0);
    send_beat(32'sd101, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd5000, 1'b0);
    send_beat(32'sd5000, 1'b0);
    wait_drained();
    write_reg(CfgSettleMs, 20'd0);
    send_beat(32'sd5000, 1'b1);
    wait_drained();
    write_reg(CfgTimeoutMs, 20'hFFFFF);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    int k;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    random_config();
    for (k = 0; k < n; k++) send_beat(rand_err(), ($urandom_range(40) == 0));
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (k = 0; k < 8; k++) send_beat(rand_err(), 1'b0);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    kp = 0; ki = 0; kd = 0; lim_reg = 786432; slew_reg = 1048575;
    band_reg = 0; settle_reg = 0; tmo_reg = 1048575;
    reset_loop();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_settle_timeout();
    test_random(125, 0, 0);
    test_random(125, 57, 0);
    test_random(125, 0, 57);
    test_random(125, 32, 32);
    test_backpressure();
    $display("Sent %0d beats, checked %0d results, over directed extremes,", sent, checked);
    $display("settle and timeout, random gains and limits, idling and a long stall.");
    if (errors == 0 && drive_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pcs_pkg.sv
rtl/pcs_div.sv
rtl/pcs_mac.sv
rtl/pid_controller_slew_settle.sv
rtl/pcs_chk.sv
verif/pid_controller_slew_settle_tb.sv
